// ===== hw/rtl/sfa_pkg.sv =====
package sfa_pkg;
   localparam int MAX_SEGMENTS_DEF = 16;
   localparam int ADDR_BITS_DEF = 16;
   localparam int OP_W = 2;
   localparam int ST_W = 2;
   localparam int SIZE_W = 17;
   localparam int OFF_W = 16;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_INIT  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOFIT    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTALLOC = 2'd3;

   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   localparam logic CSR_POLICY = 1'b0;
   localparam logic CSR_POOL   = 1'b1;

   // per-cell command broadcast by the controller
   typedef enum logic [3:0] {
      CMD_HOLD  = 4'b0001,
      CMD_INIT  = 4'b0010,
      CMD_SPLIT = 4'b0100,
      CMD_MERGE = 4'b1000
   } cmd_type;
endpackage

// ===== hw/rtl/sfa_cell.sv =====
// one table entry; shifts toward higher index on split, lower on merge
module sfa_cell import sfa_pkg::*; #(
   parameter int ADDR_BITS = ADDR_BITS_DEF,
   parameter int IDX_W = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [IDX_W-1:0]     my_idx,
   input  cmd_type              cmd,
   input  logic [IDX_W-1:0]     pick,
   input  logic [ADDR_BITS:0]   init_len,
   input  logic [ADDR_BITS:0]   req,
   input  logic [ADDR_BITS:0]   merge_len,
   input  logic                 merge_used,
   input  logic [ADDR_BITS-1:0] lo_start,
   input  logic [ADDR_BITS:0]   lo_len,
   input  logic                 lo_used,
   input  logic [ADDR_BITS-1:0] hi_start,
   input  logic [ADDR_BITS:0]   hi_len,
   input  logic                 hi_used,
   input  logic [ADDR_BITS-1:0] hi2_start,
   input  logic [ADDR_BITS:0]   hi2_len,
   input  logic                 hi2_used,
   input  logic [1:0]           merge_gap,
   output logic [ADDR_BITS-1:0] start_q,
   output logic [ADDR_BITS:0]   len_q,
   output logic                 used_q
);
   logic [ADDR_BITS-1:0] start_ff, start_in;
   logic [ADDR_BITS:0]   len_ff, len_in;
   logic                 used_ff, used_in;

   always_comb begin
      start_in = start_ff;
      len_in   = len_ff;
      used_in  = used_ff;
      unique case (cmd)
         CMD_INIT: begin
            start_in = '0;
            len_in   = (my_idx == '0) ? init_len : '0;
            used_in  = 1'b0;
         end
         CMD_SPLIT: begin
            // pick keeps request, pick+1 takes remainder, above shifts up
            if (my_idx == pick) begin
               len_in  = req;
               used_in = 1'b1;
            end else if (my_idx == pick + 1'b1) begin
               start_in = lo_start + req[ADDR_BITS-1:0];
               len_in   = lo_len - req;
               used_in  = 1'b0;
            end else if (my_idx > pick) begin
               start_in = lo_start;
               len_in   = lo_len;
               used_in  = lo_used;
            end
         end
         CMD_MERGE: begin
            // pick becomes merged segment, cells above close gap
            if (my_idx == pick) begin
               len_in  = merge_len;
               used_in = merge_used;
            end else if (my_idx > pick) begin
               if (merge_gap == 2'd2) begin
                  start_in = hi2_start;
                  len_in   = hi2_len;
                  used_in  = hi2_used;
               end else if (merge_gap == 2'd1) begin
                  start_in = hi_start;
                  len_in   = hi_len;
                  used_in  = hi_used;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         len_ff   <= (my_idx == '0) ? {1'b1, {ADDR_BITS{1'b0}}} : '0;
         used_ff  <= 1'b0;
      end else begin
         start_ff <= start_in;
         len_ff   <= len_in;
         used_ff  <= used_in;
      end
   end

   assign start_q = start_ff;
   assign len_q   = len_ff;
   assign used_q  = used_ff;
endmodule

// ===== hw/rtl/segment_fit_allocator.sv =====
// channel   | direction | ports
// request   | in        | req_valid req_ready req_op req_request_size req_block_offset
// response  | out       | rsp_valid rsp_ready rsp_status rsp_result_offset rsp_result_size
// csr       | in        | csr_write csr_index csr_data
// From acceptance to response a request passes the scan, update and output states: the scan walks
// the cell row one entry a cycle and stops after a first-fit or free hit or after the last entry,
// then the update state updates every cell at once, waiting while a previous response is held.
// A new request is accepted only in the idle state, after the last one has left the output state.
// Synchronous active-high reset restores one free segment covering 2^ADDR_BITS.
// A new request is taken while a response waits; a stalled response holds that request
// in its update cycle until the output register is free.
module segment_fit_allocator import sfa_pkg::*; #(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_op,
   input  logic [ADDR_BITS:0]   req_request_size,
   input  logic [ADDR_BITS-1:0] req_block_offset,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ST_W-1:0]      rsp_status,
   output logic [ADDR_BITS-1:0] rsp_result_offset,
   output logic [ADDR_BITS:0]   rsp_result_size,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [ADDR_BITS:0]   csr_data
);
   localparam int IDX_W = $clog2(MAX_SEGMENTS);
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam int N = MAX_SEGMENTS;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_EXEC = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]           policy_ff, policy_in;
   logic [ADDR_BITS:0]   pool_ff, pool_in;
   op_type               op_ff, op_in;
   logic [ADDR_BITS:0]   req_ff, req_in;
   logic [ADDR_BITS-1:0] off_ff, off_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     pick_ff, pick_in;
   logic [ADDR_BITS:0]   pick_len_ff, pick_len_in;
   logic                 rv_ff, rv_in;
   logic [ST_W-1:0]      st_ff, st_in;
   logic [ADDR_BITS-1:0] ro_ff, ro_in;
   logic [ADDR_BITS:0]   rs_ff, rs_in;

   logic [ADDR_BITS-1:0] c_start [N];
   logic [ADDR_BITS:0]   c_len [N];
   logic                 c_used [N];

   // scan window: current entry plus controller-selected neighbors
   logic [IDX_W-1:0]     sidx;
   logic [ADDR_BITS-1:0] s_start;
   logic [ADDR_BITS:0]   s_len;
   logic                 s_used;
   cmd_type              cmd;
   logic [IDX_W-1:0]     cmd_pick;
   logic [ADDR_BITS:0]   merge_len;
   logic                 merge_used;
   logic [1:0]           merge_gap;
   logic [ADDR_BITS:0]   init_len;
   logic                 prev_free, next_free, has_prev, has_next;
   logic [ADDR_BITS:0]   prev_len, next_len, cur_len;
   logic [ADDR_BITS-1:0] prev_start, cur_start;
   logic [IDX_W-1:0]     prev_idx, next_idx;

   assign sidx    = scan_ff[IDX_W-1:0];
   assign s_start = c_start[sidx];
   assign s_len   = c_len[sidx];
   assign s_used  = c_used[sidx];
   assign prev_idx = pick_ff - 1'b1;
   assign next_idx = pick_ff + 1'b1;
   assign has_prev = (pick_ff != '0);
   assign has_next = ({1'b0, pick_ff} + 1'b1) < count_ff;
   assign prev_free = has_prev && !c_used[prev_idx];
   assign next_free = has_next && !c_used[next_idx];
   assign prev_len = c_len[prev_idx];
   assign next_len = c_len[next_idx];
   assign cur_len = c_len[pick_ff];
   assign prev_start = c_start[prev_idx];
   assign cur_start = c_start[pick_ff];
   assign init_len = (pool_ff > {1'b1, {ADDR_BITS{1'b0}}}) ?
                     {1'b1, {ADDR_BITS{1'b0}}} : pool_ff;

   // cell row
   for (genvar g = 0; g < N; g++) begin : g_cell
      logic [ADDR_BITS-1:0] lo_s, hi_s, hi2_s;
      logic [ADDR_BITS:0]   lo_l, hi_l, hi2_l;
      logic                 lo_u, hi_u, hi2_u;
      if (g == 0) begin : g_lo0
         assign lo_s = '0; assign lo_l = '0; assign lo_u = 1'b0;
      end else begin : g_lo
         assign lo_s = c_start[g-1]; assign lo_l = c_len[g-1]; assign lo_u = c_used[g-1];
      end
      if (g + 1 < N) begin : g_hi
         assign hi_s = c_start[g+1]; assign hi_l = c_len[g+1]; assign hi_u = c_used[g+1];
      end else begin : g_hi0
         assign hi_s = '0; assign hi_l = '0; assign hi_u = 1'b0;
      end
      if (g + 2 < N) begin : g_hi2
         assign hi2_s = c_start[g+2]; assign hi2_l = c_len[g+2]; assign hi2_u = c_used[g+2];
      end else begin : g_hi20
         assign hi2_s = '0; assign hi2_l = '0; assign hi2_u = 1'b0;
      end
      sfa_cell #(.ADDR_BITS(ADDR_BITS), .IDX_W(IDX_W)) u_cell (
         .clock(clock), .reset(reset),
         .my_idx(IDX_W'(g)), .cmd(cmd), .pick(cmd_pick),
         .init_len(init_len), .req(req_ff),
         .merge_len(merge_len), .merge_used(merge_used),
         .lo_start(lo_s), .lo_len(lo_l), .lo_used(lo_u),
         .hi_start(hi_s), .hi_len(hi_l), .hi_used(hi_u),
         .hi2_start(hi2_s), .hi2_len(hi2_l), .hi2_used(hi2_u),
         .merge_gap(merge_gap),
         .start_q(c_start[g]), .len_q(c_len[g]), .used_q(c_used[g])
      );
   end

   assign req_ready = (state_ff == S_IDLE);

   // controller
   always_comb begin
      logic fits;
      logic better;
      state_in = state_ff;
      policy_in = policy_ff;
      pool_in = pool_ff;
      op_in = op_ff;
      req_in = req_ff;
      off_in = off_ff;
      count_in = count_ff;
      scan_in = scan_ff;
      found_in = found_ff;
      pick_in = pick_ff;
      pick_len_in = pick_len_ff;
      rv_in = rv_ff;
      st_in = st_ff;
      ro_in = ro_ff;
      rs_in = rs_ff;
      cmd = CMD_HOLD;
      cmd_pick = pick_ff;
      merge_len = cur_len;
      merge_used = 1'b0;
      merge_gap = 2'd0;
      fits = 1'b0;
      better = 1'b0;

      if (csr_write) begin
         if (csr_index == CSR_POLICY) policy_in = csr_data[1:0];
         else pool_in = csr_data;
      end
      if (rv_ff && rsp_ready) rv_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               op_in = op_type'(req_op);
               req_in = req_request_size;
               off_in = req_block_offset;
               scan_in = '0;
               found_in = 1'b0;
               pick_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // one entry per cycle
            if (scan_ff < count_ff && !(found_ff && op_ff == OP_ALLOC &&
                policy_ff != POL_BEST && policy_ff != POL_WORST) &&
                !(found_ff && op_ff == OP_FREE)) begin
               if (op_ff == OP_ALLOC) begin
                  fits = !s_used && req_ff != '0 && s_len >= req_ff;
                  better = (policy_ff == POL_BEST) ? (s_len < pick_len_ff) :
                           (policy_ff == POL_WORST) ? (s_len > pick_len_ff) : 1'b0;
                  if (fits && (!found_ff || better)) begin
                     found_in = 1'b1;
                     pick_in = sidx;
                     pick_len_in = s_len;
                  end
               end else if (s_used && s_start == off_ff) begin
                  found_in = 1'b1;
                  pick_in = sidx;
               end
               scan_in = scan_ff + 1'b1;
            end else begin
               state_in = S_EXEC;
            end
            if (op_ff == OP_INIT || op_ff == OP_NONE) state_in = S_EXEC;
         end
         S_EXEC: begin
            // wait while the previous response is still held
            if (!(rv_ff && !rsp_ready)) begin
               st_in = ST_OK; ro_in = '0; rs_in = '0;
               unique case (op_ff)
                  OP_ALLOC: begin
                     if (!found_ff) st_in = ST_NOFIT;
                     else if (pick_len_ff > req_ff && count_ff >= CNT_W'(N)) st_in = ST_FULL;
                     else begin
                        ro_in = cur_start; rs_in = req_ff;
                        if (pick_len_ff > req_ff) begin
                           cmd = CMD_SPLIT;
                           count_in = count_ff + 1'b1;
                        end else begin
                           // exact fit: mark used via merge path
                           cmd = CMD_MERGE;
                           merge_len = cur_len;
                           merge_used = 1'b1;
                        end
                     end
                  end
                  OP_FREE: begin
                     if (!found_ff) st_in = ST_NOTALLOC;
                     else begin
                        cmd = CMD_MERGE;
                        merge_len = cur_len;
                        ro_in = cur_start;
                        if (prev_free) begin
                           cmd_pick = prev_idx;
                           merge_len = prev_len + cur_len;
                           ro_in = prev_start;
                        end
                        if (next_free) merge_len = merge_len + next_len;
                        merge_gap = {1'b0, prev_free} + {1'b0, next_free};
                        count_in = count_ff - CNT_W'(merge_gap);
                        rs_in = merge_len;
                     end
                  end
                  OP_INIT: begin
                     cmd = CMD_INIT;
                     count_in = CNT_W'(1);
                     rs_in = init_len;
                  end
                  default: ;
               endcase
               rv_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         policy_ff <= '0;
         pool_ff <= {1'b1, {ADDR_BITS{1'b0}}};
         count_ff <= CNT_W'(1);
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         policy_ff <= policy_in;
         pool_ff <= pool_in;
         count_ff <= count_in;
         rv_ff <= rv_in;
      end
      op_ff <= op_in;
      req_ff <= req_in;
      off_ff <= off_in;
      scan_ff <= scan_in;
      found_ff <= found_in;
      pick_ff <= pick_in;
      pick_len_ff <= pick_len_in;
      st_ff <= st_in;
      ro_ff <= ro_in;
      rs_ff <= rs_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_result_offset = ro_ff;
   assign rsp_result_size = rs_ff;

   // segment count stays within table
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CNT_W'(1) && count_ff <= CNT_W'(N))
      else $error("segment count out of range");
   // a response is produced only from the update state
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(state_ff) == S_EXEC)
      else $error("response without update");
   // a waiting response keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_ready |=> rv_ff && $stable(st_ff) && $stable(ro_ff) && $stable(rs_ff))
      else $error("response changed while waiting");
endmodule
